@@ design/geo2px_pkg.sv @@
// ----------------------------------------------------------------------------
// geo2px_pkg
// types and constants shared by the geographic-to-pixel converter
// ----------------------------------------------------------------------------
package geo2px_pkg;

  localparam int LNG_W  = 29;
  localparam int LAT_W  = 28;
  localparam int PIX_W  = 16;
  localparam int CNT_CFG_W = 5;
  localparam int DIFF_W = 30;               // coordinate differences
  localparam int DPIX_W = PIX_W + 1;        // pixel differences
  localparam int PROD_W = DIFF_W + DPIX_W;  // dq * dp
  localparam int SQA_W  = 2 * DIFF_W;
  localparam int SQB_W  = 2 * (LAT_W + 1);
  localparam int DIST_W = SQA_W + 1;
  localparam int NUM_W  = PROD_W + 9;       // 2 * 256 * |dq*dp| + |dk|
  localparam int DEN_W  = DIFF_W + 1;       // 2 * |dk|
  localparam int RES_W  = NUM_W + 2;

  // square of 180 degrees in microdegrees
  localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(64'd32400000000000000);

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EQ_LNG  = 2'd1;
  localparam logic [1:0] STAT_EQ_LAT  = 2'd2;

  typedef struct packed {
    logic [LNG_W-1:0] lng;
    logic [LAT_W-1:0] lat;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_SETUP,
    ST_DIV,
    ST_FIN,
    ST_HOLD
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [RES_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(RES_W'(64'sd2147483647))) begin
      r = 32'h7fff_ffff;
    end else if (v < -$signed(RES_W'(64'sd2147483648))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/geo_to_pixel_two_nearest_interp.sv @@
// ----------------------------------------------------------------------------
// geo_to_pixel_two_nearest_interp
// maps longitude/latitude to pixel position from the two nearest table points
// ----------------------------------------------------------------------------
// sequence: a write transfer sets a zero result on acceptance, which then
//   moves to the output register; a convert runs a table scan (one entry per
//   cycle), multiply, setup, parallel bit-serial x and y division, finish
// throughput: one item at a time; the next item is taken once the result
//   sits in the output register
// reset: synchronous active-low; table contents undefined until written,
//   sample_count resets to 2
module geo_to_pixel_two_nearest_interp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index[3:0], longitude[32:4], latitude[60:33], pixel_col[76:61],
  // pixel_row[92:77], zero fill
  input  logic [95:0] in_tdata,
  // action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // map_x[31:0], map_y[63:32], nearest_entry[67:64], second_entry[71:68]
  output logic [71:0] out_tdata,
  // status
  output logic [1:0]  out_tuser
);
  import geo2px_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [CNT_CFG_W-1:0] sample_count_r;
  logic [CNT_W-1:0]     count_w;

  logic [3:0]       in_idx;
  entry_t           in_ent;
  logic             wr_en;
  logic             scan_start, div_start, out_load;

  logic [LNG_W-1:0] q_lng_r;
  logic [LAT_W-1:0] q_lat_r;

  logic             sc_done;
  logic [IDX_W-1:0] sc_n1_idx, sc_n2_idx;
  entry_t           sc_n1, sc_n2;

  logic signed [DIFF_W-1:0] dq_x, dq_y, dk_x, dk_y;
  logic signed [DPIX_W-1:0] dp_x, dp_y;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [DIFF_W-1:0] dk_x_r, dk_y_r;

  logic [PROD_W-1:0] m_x, m_y;
  logic [DIFF_W-1:0] d_x, d_y;
  logic [NUM_W-1:0]  num_x, num_y, quo_x, quo_y;
  logic [DEN_W-1:0]  den_x, den_y;
  logic              neg_x_r, neg_y_r;
  logic              div_x_done, div_y_done;

  logic signed [RES_W-1:0] a_x, a_y, r_x, r_y;

  logic [31:0] res_x_r, res_y_r;
  logic [1:0]  res_st_r;
  logic [3:0]  res_n1_r, res_n2_r;

  logic        out_tvalid_r;
  logic [71:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  assign in_idx = in_tdata[3:0];
  assign in_ent = '{lng: in_tdata[32:4], lat: in_tdata[60:33],
                    col: in_tdata[76:61], row: in_tdata[92:77]};

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_CFG_W'(2);
    end else if (cfg_valid) begin
      sample_count_r <= cfg_data;
    end
  end

  always_comb begin
    if (sample_count_r < CNT_CFG_W'(2)) begin
      count_w = CNT_W'(2);
    end else if (32'(sample_count_r) > TABLE_DEPTH) begin
      count_w = CNT_W'(TABLE_DEPTH);
    end else begin
      count_w = CNT_W'(sample_count_r);
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser == ACT_CONVERT) ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (sc_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_x_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:   state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    scan_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        scan_start = in_tvalid && in_tuser == ACT_CONVERT;
      end
      ST_SETUP: div_start = 1'b1;
      ST_HOLD:  out_load  = !out_tvalid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign wr_en = in_tvalid && in_tready && in_tuser == ACT_WRITE
                 && 32'(in_idx) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      q_lng_r <= in_ent.lng;
      q_lat_r <= in_ent.lat;
    end
  end

  geo2px_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_idx)),
    .wr_data (in_ent),
    .start   (scan_start),
    .count   (count_w),
    .q_lng   (q_lng_r),
    .q_lat   (q_lat_r),
    .done    (sc_done),
    .n1_idx  (sc_n1_idx),
    .n2_idx  (sc_n2_idx),
    .n1_ent  (sc_n1),
    .n2_ent  (sc_n2)
  );

  // differences along the line through the two picks
  always_comb begin
    dq_x = DIFF_W'($signed(q_lng_r)) - DIFF_W'($signed(sc_n1.lng));
    dk_x = DIFF_W'($signed(sc_n2.lng)) - DIFF_W'($signed(sc_n1.lng));
    dq_y = DIFF_W'($signed(q_lat_r)) - DIFF_W'($signed(sc_n1.lat));
    dk_y = DIFF_W'($signed(sc_n2.lat)) - DIFF_W'($signed(sc_n1.lat));
    dp_x = $signed({1'b0, sc_n2.col}) - $signed({1'b0, sc_n1.col});
    dp_y = $signed({1'b0, sc_n2.row}) - $signed({1'b0, sc_n1.row});
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_x_r <= dq_x * dp_x;
      prod_y_r <= dq_y * dp_y;
      dk_x_r   <= dk_x;
      dk_y_r   <= dk_y;
    end
  end

  // rounded quotient: (2*|num| + |dk|) / (2*|dk|), num = 256 * dq * dp
  always_comb begin
    m_x   = prod_x_r[PROD_W-1] ? PROD_W'(-prod_x_r) : PROD_W'(prod_x_r);
    m_y   = prod_y_r[PROD_W-1] ? PROD_W'(-prod_y_r) : PROD_W'(prod_y_r);
    d_x   = dk_x_r[DIFF_W-1] ? DIFF_W'(-dk_x_r) : DIFF_W'(dk_x_r);
    d_y   = dk_y_r[DIFF_W-1] ? DIFF_W'(-dk_y_r) : DIFF_W'(dk_y_r);
    num_x = {m_x, 9'd0} + NUM_W'(d_x);
    num_y = {m_y, 9'd0} + NUM_W'(d_y);
    den_x = {d_x, 1'b0};
    den_y = {d_y, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_x_r <= prod_x_r[PROD_W-1] ^ dk_x_r[DIFF_W-1];
      neg_y_r <= prod_y_r[PROD_W-1] ^ dk_y_r[DIFF_W-1];
    end
  end

  geo2px_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x),
    .den   (den_x),
    .done  (div_x_done),
    .quo   (quo_x)
  );

  geo2px_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_y),
    .den   (den_y),
    .done  (div_y_done),
    .quo   (quo_y)
  );

  always_comb begin
    a_x = $signed(RES_W'({sc_n1.col, 8'd0}));
    a_y = $signed(RES_W'({sc_n1.row, 8'd0}));
    r_x = neg_x_r ? a_x - $signed(RES_W'(quo_x)) : a_x + $signed(RES_W'(quo_x));
    r_y = neg_y_r ? a_y - $signed(RES_W'(quo_y)) : a_y + $signed(RES_W'(quo_y));
  end

  // result held until the output register is free
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && in_tuser == ACT_WRITE) begin
      res_x_r  <= '0;
      res_y_r  <= '0;
      res_st_r <= STAT_OK;
      res_n1_r <= '0;
      res_n2_r <= '0;
    end else if (state_r == ST_FIN) begin
      res_st_r <= ((dk_x_r == '0) ? STAT_EQ_LNG : STAT_OK)
                | ((dk_y_r == '0) ? STAT_EQ_LAT : STAT_OK);
      res_x_r  <= (dk_x_r == '0) ? 32'({sc_n1.col, 8'd0}) : sat32(r_x);
      res_y_r  <= (dk_y_r == '0) ? 32'({sc_n1.row, 8'd0}) : sat32(r_y);
      res_n1_r <= 4'(sc_n1_idx);
      res_n2_r <= 4'(sc_n2_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {res_n2_r, res_n1_r, res_y_r, res_x_r};
      out_tuser_r <= res_st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> state_r == ST_SCAN)
    else $error("scan finished outside scan phase");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_x_done |-> state_r == ST_DIV)
    else $error("division finished outside divide phase");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_x_done == div_y_done)
    else $error("x and y dividers out of step");

  a_convert_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ACT_CONVERT) |=> state_r == ST_SCAN)
    else $error("convert transfer did not start a scan");
`endif

endmodule

@@ design/geo2px_div.sv @@
// ----------------------------------------------------------------------------
// geo2px_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module geo2px_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [geo2px_pkg::NUM_W-1:0]  num,
  input  logic [geo2px_pkg::DEN_W-1:0]  den,
  output logic                          done,
  output logic [geo2px_pkg::NUM_W-1:0]  quo
);
  import geo2px_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  qn_r;
  logic [DEN_W:0]    rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r[DEN_W-1:0], qn_r[NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn_r   <= num;
      rem_r  <= '0;
      den_r  <= den;
      step_r <= STEP_W'(NUM_W);
    end else if (busy_r) begin
      rem_r  <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
      qn_r   <= {qn_r[NUM_W-2:0], fits};
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = qn_r;

endmodule

@@ design/geo2px_scan.sv @@
// ----------------------------------------------------------------------------
// geo2px_scan
// calibration table memory and nearest-pair search pipeline
// ----------------------------------------------------------------------------
module geo2px_scan #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_addr,
  input  geo2px_pkg::entry_t            wr_data,
  input  logic                          start,
  input  logic [CNT_W-1:0]              count,
  input  logic [geo2px_pkg::LNG_W-1:0]  q_lng,
  input  logic [geo2px_pkg::LAT_W-1:0]  q_lat,
  output logic                          done,
  output logic [IDX_W-1:0]              n1_idx,
  output logic [IDX_W-1:0]              n2_idx,
  output geo2px_pkg::entry_t            n1_ent,
  output geo2px_pkg::entry_t            n2_ent
);
  import geo2px_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  logic [CNT_W-1:0] rd_cnt_r;
  logic [CNT_W-1:0] last_r;
  logic             issue_r;

  logic             p1_vld_r, p1_last_r;
  logic [IDX_W-1:0] p1_idx_r;
  logic             p2_vld_r, p2_last_r;
  logic [IDX_W-1:0] p2_idx_r;
  entry_t           p2_ent_r;
  logic [SQA_W-1:0] sq_a_r;
  logic [SQB_W-1:0] sq_b_r;

  logic signed [DIFF_W-1:0] da;
  logic signed [LAT_W:0]    db;
  logic [DIFF_W-1:0]        a_mag;
  logic [LAT_W:0]           b_mag;
  logic [SQA_W-1:0]         sq_a;
  logic [SQB_W-1:0]         sq_b;

  logic [DIST_W-1:0] d1_r, d2_r, sq_dist;
  logic [IDX_W-1:0]  n1_r, n2_r;
  entry_t            n1_ent_r, n2_ent_r, eff1, eff2;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue_r) begin
      rd_data_r <= mem[rd_cnt_r[IDX_W-1:0]];
    end
  end

  // read issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (start) begin
        issue_r <= 1'b1;
      end else if (issue_r && rd_cnt_r == last_r) begin
        issue_r <= 1'b0;
      end
      p1_vld_r <= issue_r;
      p2_vld_r <= p1_vld_r;
      done_r   <= p2_vld_r && p2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_cnt_r <= '0;
      last_r   <= count - CNT_W'(1);
    end else if (issue_r) begin
      rd_cnt_r <= rd_cnt_r + CNT_W'(1);
    end
    p1_idx_r  <= rd_cnt_r[IDX_W-1:0];
    p1_last_r <= rd_cnt_r == last_r;
  end

  // squared distance terms
  always_comb begin
    da    = $signed({rd_data_r.lng[LNG_W-1], rd_data_r.lng}) - $signed({q_lng[LNG_W-1], q_lng});
    db    = $signed({rd_data_r.lat[LAT_W-1], rd_data_r.lat}) - $signed({q_lat[LAT_W-1], q_lat});
    a_mag = da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da);
    b_mag = db[LAT_W] ? (LAT_W+1)'(-db) : (LAT_W+1)'(db);
    sq_a  = a_mag * a_mag;
    sq_b  = b_mag * b_mag;
  end

  always_ff @(posedge clk) begin
    sq_a_r    <= sq_a;
    sq_b_r    <= sq_b;
    p2_ent_r  <= rd_data_r;
    p2_idx_r  <= p1_idx_r;
    p2_last_r <= p1_last_r;
  end

  // the default picks are entries 0 and 1, their data arrives as they pass
  always_comb begin
    sq_dist = DIST_W'(sq_a_r) + DIST_W'(sq_b_r);
    eff1 = (p2_idx_r == '0) ? p2_ent_r : n1_ent_r;
    eff2 = (p2_idx_r == IDX_W'(1) && n2_r == IDX_W'(1)) ? p2_ent_r : n2_ent_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d1_r <= DIST_LIMIT;
      d2_r <= DIST_LIMIT;
      n1_r <= '0;
      n2_r <= IDX_W'(1);
    end else if (p2_vld_r) begin
      if (sq_dist < d1_r) begin
        d2_r     <= d1_r;
        n2_r     <= n1_r;
        n2_ent_r <= eff1;
        d1_r     <= sq_dist;
        n1_r     <= p2_idx_r;
        n1_ent_r <= p2_ent_r;
      end else if (sq_dist < d2_r) begin
        d2_r     <= sq_dist;
        n2_r     <= p2_idx_r;
        n2_ent_r <= p2_ent_r;
        n1_ent_r <= eff1;
      end else begin
        n1_ent_r <= eff1;
        n2_ent_r <= eff2;
      end
    end
  end

  assign done   = done_r;
  assign n1_idx = n1_r;
  assign n2_idx = n2_r;
  assign n1_ent = n1_ent_r;
  assign n2_ent = n2_ent_r;

endmodule
